[hdl/sscnt_pkg.sv]
// Shared types, constants and helpers for the scan segment sample count block.
`timescale 1ns / 1ps
`default_nettype none
package sscnt_pkg;

   localparam logic [23:0] COUNT_MAX        = 24'hFFFFFF;
   localparam logic [22:0] AXIS_TAN         = 23'd4294969;   // round(tan(0.001) * 2^32)
   localparam logic [20:0] SAMPLE_TIME_INIT = 21'd5243;

   // register indexes of the csr port
   localparam logic [2:0] CSR_SAMPLE_TIME = 3'd0;
   localparam logic [2:0] CSR_ACCEL_X     = 3'd1;
   localparam logic [2:0] CSR_ACCEL_Y     = 3'd2;
   localparam logic [2:0] CSR_VMAX_X      = 3'd3;
   localparam logic [2:0] CSR_VMAX_Y      = 3'd4;

   // one classified request between front and back
   typedef struct packed {
      logic [31:0] leg_x;    // |end_x - start_x|
      logic [31:0] leg_y;    // |end_y - start_y|
      logic        near_x;   // x-axis limits apply
      logic        near_y;   // y-axis limits apply
   } item_type;

   typedef struct packed {
      logic [20:0] sample_time;
      logic [31:0] accel_x;
      logic [31:0] accel_y;
      logic [31:0] vmax_x;
      logic [31:0] vmax_y;
   } cfg_type;

   typedef enum logic [1:0] {ALU_MUL, ALU_DIV, ALU_SQRT} alu_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DD, S_EE, S_ROOT, S_P_MUL, S_P_DIV, S_DECIDE,
      S_Z_MUL, S_Z_DIV, S_DA, S_VV, S_CMP, S_AV, S_AVT, S_TP_DIV,
      S_TR_DIV, S_TR_SQ, S_TR_T, S_DONE
   } state_type;

   // saturate a quotient into the count range; plus_one adds the closing sample
   function automatic logic [23:0] sat_count(input logic [127:0] q, input logic plus_one);
      logic [23:0] r;
      if (q[127:24] != '0) r = COUNT_MAX;
      else if (plus_one) r = (q[23:0] == COUNT_MAX) ? COUNT_MAX : q[23:0] + 24'd1;
      else r = (q[23:0] == 24'd0) ? 24'd1 : q[23:0];
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/sscnt_fifo.sv]
// Two-entry queue of classified requests between front and back.
`timescale 1ns / 1ps
`default_nettype none
module sscnt_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire sscnt_pkg::item_type wr_data,
   output logic                    full,
   input  wire logic               rd_en,
   output sscnt_pkg::item_type     rd_data,
   output logic                    valid
);
   import sscnt_pkg::*;

   item_type   mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   logic do_wr, do_rd;
   assign do_wr = wr_en && (cnt_ff != 2'd2);
   assign do_rd = rd_en && (cnt_ff != 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign rd_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ do_wr;
      rptr_in = rptr_ff ^ do_rd;
      cnt_in  = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wptr_ff] <= wr_data;
   end
endmodule
`default_nettype wire

[hdl/sscnt_front.sv]
// Front end: takes requests, forms leg lengths and the near-axis test.
`timescale 1ns / 1ps
`default_nettype none
module sscnt_front (
   input  wire logic signed [31:0] start_x,
   input  wire logic signed [31:0] start_y,
   input  wire logic signed [31:0] end_x,
   input  wire logic signed [31:0] end_y,
   output sscnt_pkg::item_type     item
);
   import sscnt_pkg::*;

   logic signed [32:0] dx, dy;
   logic [32:0]        ax, ay;
   logic [63:0]        ex_sh, dx_sh;
   logic [54:0]        kt_d, kt_e;
   logic               zero_len;

   always_comb begin
      dx = 33'(end_x) - 33'(start_x);
      dy = 33'(end_y) - 33'(start_y);
      ax = dx[32] ? 33'(-dx) : 33'(dx);
      ay = dy[32] ? 33'(-dy) : 33'(dy);
      item.leg_x = ax[31:0];
      item.leg_y = ay[31:0];
      ex_sh = {item.leg_y, 32'd0};
      dx_sh = {item.leg_x, 32'd0};
      kt_d  = 55'(AXIS_TAN) * 55'(item.leg_x);
      kt_e  = 55'(AXIS_TAN) * 55'(item.leg_y);
      zero_len = (item.leg_x == 32'd0) && (item.leg_y == 32'd0);
      item.near_x = zero_len || (ex_sh < 64'(kt_d));
      item.near_y = !item.near_x && (dx_sh < 64'(kt_e));
   end
endmodule
`default_nettype wire

[hdl/sscnt_alu.sv]
// Shared iterative unit: shift-add multiply, restoring divide, bit-pair square root.
`timescale 1ns / 1ps
`default_nettype none
module sscnt_alu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire sscnt_pkg::alu_op_type op,
   input  wire logic [127:0]          a,
   input  wire logic [127:0]          b,
   output logic                       done,
   output logic [127:0]               result
);
   import sscnt_pkg::*;

   alu_op_type   op_ff, op_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] x_ff, x_in, y_ff, y_in;
   logic [128:0] acc_ff, acc_in;
   logic [63:0]  root_ff, root_in;

   logic [128:0] rdiv;
   logic [129:0] rsq, trial;

   always_comb begin
      op_in = op_ff; busy_in = busy_ff; done_in = 1'b0; cnt_in = cnt_ff;
      x_in = x_ff; y_in = y_ff; acc_in = acc_ff; root_in = root_ff;
      rdiv  = {acc_ff[127:0], x_ff[127]};
      rsq   = {acc_ff[127:0], x_ff[127:126]};
      trial = {64'd0, root_ff, 2'b01};
      if (start) begin
         op_in = op; busy_in = 1'b1; x_in = a; y_in = b;
         acc_in = '0; root_in = '0;
         cnt_in = (op == ALU_DIV) ? 7'd127 : 7'd63;
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_MUL: begin
               if (y_ff[0]) acc_in = {1'b0, acc_ff[127:0] + x_ff};
               x_in = {x_ff[126:0], 1'b0};
               y_in = {1'b0, y_ff[127:1]};
            end
            ALU_DIV: begin
               if (rdiv >= {1'b0, y_ff}) begin
                  acc_in = rdiv - {1'b0, y_ff};
                  x_in   = {x_ff[126:0], 1'b1};
               end else begin
                  acc_in = rdiv;
                  x_in   = {x_ff[126:0], 1'b0};
               end
            end
            ALU_SQRT: begin
               if (rsq >= trial) begin
                  acc_in  = 129'(rsq - trial);
                  root_in = {root_ff[62:0], 1'b1};
               end else begin
                  acc_in  = rsq[128:0];
                  root_in = {root_ff[62:0], 1'b0};
               end
               x_in = {x_ff[125:0], 2'b00};
            end
            default: ;
         endcase
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (op_ff)
         ALU_MUL:  result = acc_ff[127:0];
         ALU_DIV:  result = x_ff;
         ALU_SQRT: result = {64'd0, root_ff};
         default:  result = '0;
      endcase
   end
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      root_ff <= root_in;
   end
endmodule
`default_nettype wire

[hdl/sscnt_back.sv]
// Back end: sequences path length, limits and profile count on the shared unit.
`timescale 1ns / 1ps
`default_nettype none
module sscnt_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sscnt_pkg::cfg_type  cfg,
   input  wire logic                q_valid,
   input  wire sscnt_pkg::item_type q_item,
   output logic                     q_pop,
   output logic                     out_valid,
   output logic [23:0]              out_count,
   output logic                     out_fault,
   input  wire logic                out_pop
);
   import sscnt_pkg::*;

   state_type    state_ff, state_in;
   logic         issued_ff, issued_in;
   logic [1:0]   k_ff;
   item_type     it_ff;
   logic [127:0] dd_ff, tmp_ff;
   logic [32:0]  d_ff;
   logic [63:0]  a_ff, v_ff;
   logic [23:0]  pc_ff, rc_ff;
   logic         pf_ff, rf_ff, rv_ff;

   logic         alu_start, alu_done, op_state, fin, fin_flt;
   alu_op_type   alu_op;
   logic [127:0] alu_a, alu_b, alu_res;
   logic [23:0]  fin_cnt;
   logic [31:0]  lim_k, leg_k;
   logic [63:0]  q64;
   logic         t_zero, trap;

   sscnt_alu u_alu (
      .clock(clock), .reset(reset), .start(alu_start), .op(alu_op),
      .a(alu_a), .b(alu_b), .done(alu_done), .result(alu_res)
   );

   always_comb begin
      unique case (k_ff)
         2'd0:    lim_k = cfg.accel_x;
         2'd1:    lim_k = cfg.accel_y;
         2'd2:    lim_k = cfg.vmax_x;
         default: lim_k = cfg.vmax_y;
      endcase
      leg_k  = k_ff[0] ? it_ff.leg_y : it_ff.leg_x;
      q64    = alu_res[63:0];
      t_zero = (cfg.sample_time == 21'd0);
      trap   = dd_ff < tmp_ff;   // V^2 < d*A
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (q_valid) state_in = S_DD;
         S_DD:    if (alu_done) state_in = S_EE;
         S_EE:    if (alu_done) state_in = S_ROOT;
         S_ROOT:  if (alu_done) state_in = (it_ff.near_x || it_ff.near_y) ? S_DECIDE : S_P_MUL;
         S_P_MUL: if (alu_done) state_in = S_P_DIV;
         S_P_DIV: if (alu_done) state_in = (k_ff == 2'd3) ? S_DECIDE : S_P_MUL;
         S_DECIDE: begin
            if (a_ff != '0) state_in = S_DA;
            else if (v_ff == '0 || t_zero) state_in = S_DONE;
            else state_in = S_Z_MUL;
         end
         S_Z_MUL: if (alu_done) state_in = S_Z_DIV;
         S_Z_DIV: if (alu_done) state_in = S_DONE;
         S_DA:    if (alu_done) state_in = S_VV;
         S_VV:    if (alu_done) state_in = S_CMP;
         S_CMP: begin
            if (trap) state_in = (v_ff == '0 || t_zero) ? S_DONE : S_AV;
            else state_in = t_zero ? S_DONE : S_TR_DIV;
         end
         S_AV:     if (alu_done) state_in = S_AVT;
         S_AVT:    if (alu_done) state_in = S_TP_DIV;
         S_TP_DIV: if (alu_done) state_in = S_DONE;
         S_TR_DIV: if (alu_done) state_in = S_TR_SQ;
         S_TR_SQ:  if (alu_done) state_in = S_TR_T;
         S_TR_T:   if (alu_done) state_in = S_DONE;
         S_DONE:   if (!rv_ff || out_pop) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs: unit operands, finish value
   always_comb begin
      op_state = 1'b1; alu_op = ALU_MUL; alu_a = '0; alu_b = '0;
      fin = 1'b0; fin_cnt = COUNT_MAX; fin_flt = 1'b0;
      q_pop = 1'b0;
      unique case (state_ff)
         S_IDLE: begin op_state = 1'b0; q_pop = q_valid; end
         S_DD:    begin alu_a = 128'(it_ff.leg_x); alu_b = 128'(it_ff.leg_x); end
         S_EE:    begin alu_a = 128'(it_ff.leg_y); alu_b = 128'(it_ff.leg_y); end
         S_ROOT:  begin alu_op = ALU_SQRT; alu_a = dd_ff; end
         S_P_MUL: begin alu_a = 128'(lim_k); alu_b = 128'(d_ff); end
         S_P_DIV: begin alu_op = ALU_DIV; alu_a = tmp_ff; alu_b = 128'(leg_k); end
         S_DECIDE: begin
            op_state = 1'b0;
            if (a_ff == '0 && (v_ff == '0 || t_zero)) begin
               fin = 1'b1; fin_flt = (v_ff == '0);
            end
         end
         S_Z_MUL: begin alu_a = 128'(v_ff); alu_b = 128'(cfg.sample_time); end
         S_Z_DIV: begin
            alu_op = ALU_DIV; alu_a = {75'd0, d_ff, 20'd0}; alu_b = tmp_ff;
            fin = alu_done; fin_cnt = sat_count(alu_res, 1'b0);
         end
         S_DA: begin alu_a = 128'(d_ff); alu_b = 128'(a_ff); end
         S_VV: begin alu_a = 128'(v_ff); alu_b = 128'(v_ff); end
         S_CMP: begin
            op_state = 1'b0;
            if (trap) begin
               fin = (v_ff == '0) || t_zero; fin_flt = (v_ff == '0);
            end else begin
               fin = t_zero;
            end
         end
         S_AV:  begin alu_a = 128'(a_ff); alu_b = 128'(v_ff); end
         S_AVT: begin alu_a = tmp_ff; alu_b = 128'(cfg.sample_time); end
         S_TP_DIV: begin
            alu_op = ALU_DIV; alu_a = {dd_ff[107:0], 20'd0}; alu_b = tmp_ff;
            fin = alu_done; fin_cnt = sat_count(alu_res, 1'b1);
         end
         S_TR_DIV: begin
            alu_op = ALU_DIV; alu_a = {53'd0, d_ff, 42'd0}; alu_b = 128'(a_ff);
         end
         S_TR_SQ: begin alu_op = ALU_SQRT; alu_a = tmp_ff; end
         S_TR_T: begin
            alu_op = ALU_DIV; alu_a = tmp_ff; alu_b = 128'(cfg.sample_time);
            fin = alu_done; fin_cnt = sat_count(alu_res, 1'b1);
         end
         S_DONE:  op_state = 1'b0;
         default: op_state = 1'b0;
      endcase
      alu_start = op_state && !issued_ff;
      issued_in = op_state && !alu_done && (issued_ff || alu_start);
   end

   assign out_valid = rv_ff;
   assign out_count = rc_ff;
   assign out_fault = rf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         if (state_ff == S_DONE && (!rv_ff || out_pop)) rv_ff <= 1'b1;
         else if (out_pop) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_valid) it_ff <= q_item;
      if (fin) begin
         pc_ff <= fin_cnt;
         pf_ff <= fin_flt;
      end
      if (state_ff == S_DONE && (!rv_ff || out_pop)) begin
         rc_ff <= pc_ff;
         rf_ff <= pf_ff;
      end
      if (state_ff == S_CMP) dd_ff <= dd_ff + tmp_ff;   // V^2 + d*A
      if (alu_done) begin
         unique case (state_ff)
            S_DD: dd_ff <= alu_res;
            S_EE: dd_ff <= dd_ff + alu_res;
            S_ROOT: begin
               d_ff <= alu_res[32:0];
               k_ff <= 2'd0;
               if (it_ff.near_x) begin
                  a_ff <= 64'(cfg.accel_x); v_ff <= 64'(cfg.vmax_x);
               end else begin
                  a_ff <= 64'(cfg.accel_y); v_ff <= 64'(cfg.vmax_y);
               end
            end
            S_P_DIV: begin
               k_ff <= k_ff + 2'd1;
               unique case (k_ff)
                  2'd0:    a_ff <= q64;
                  2'd1:    if (q64 < a_ff) a_ff <= q64;
                  2'd2:    v_ff <= q64;
                  default: if (q64 < v_ff) v_ff <= q64;
               endcase
            end
            S_VV: dd_ff <= alu_res;
            S_P_MUL, S_Z_MUL, S_DA, S_AV, S_AVT, S_TR_DIV, S_TR_SQ: tmp_ff <= alu_res;
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

[hdl/scan_segment_sample_count_core.sv]
// Top level of the scan segment sample count block.
// Work per request: the operations it runs in turn on the shared unit, where a divide takes
//   longer than a multiply or square root; an off-axis triangle needs the most of them.
// Flow: the back end works on one request at a time; a 2-deep queue lets the front
//   take two more requests while one is in work, and one result waits in its own register.
// Reset: synchronous, active high; empties queue and result, loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module scan_segment_sample_count_core (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               push,
   output logic                    full,
   input  wire logic signed [31:0] req_start_x,
   input  wire logic signed [31:0] req_start_y,
   input  wire logic signed [31:0] req_end_x,
   input  wire logic signed [31:0] req_end_y,
   // result channel
   output logic                    empty,
   input  wire logic               pop,
   output logic [23:0]             rsp_sample_count,
   output logic                    rsp_fault,
   // register write port
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import sscnt_pkg::*;

   // configuration registers; the user must write them only while idle, the block does not enforce it
   cfg_type  cfg_ff;

   item_type front_item, q_item;
   logic     q_valid, q_pop, rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_time <= SAMPLE_TIME_INIT;
         cfg_ff.accel_x     <= '0;
         cfg_ff.accel_y     <= '0;
         cfg_ff.vmax_x      <= '0;
         cfg_ff.vmax_y      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SAMPLE_TIME: cfg_ff.sample_time <= csr_data[20:0];
            CSR_ACCEL_X:     cfg_ff.accel_x     <= csr_data;
            CSR_ACCEL_Y:     cfg_ff.accel_y     <= csr_data;
            CSR_VMAX_X:      cfg_ff.vmax_x      <= csr_data;
            CSR_VMAX_Y:      cfg_ff.vmax_y      <= csr_data;
            default: ;       // unused indexes are dropped
         endcase
      end
   end

   // front: legs and axis classification, straight into the queue
   sscnt_front u_front (
      .start_x(req_start_x), .start_y(req_start_y),
      .end_x(req_end_x), .end_y(req_end_y), .item(front_item)
   );

   sscnt_fifo u_fifo (
      .clock(clock), .reset(reset),
      .wr_en(push), .wr_data(front_item), .full(full),
      .rd_en(q_pop), .rd_data(q_item), .valid(q_valid)
   );

   // back: path length, limits, profile, saturation
   sscnt_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .out_valid(rsp_valid), .out_count(rsp_sample_count),
      .out_fault(rsp_fault), .out_pop(pop)
   );

   assign empty = !rsp_valid;
endmodule
`default_nettype wire

[hdl/sscnt_checker.sv]
// Port-level checks on the top level, bound in below.
`timescale 1ns / 1ps
`default_nettype none
module sscnt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [23:0] rsp_sample_count,
   input wire logic        rsp_fault
);
   import sscnt_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("waiting result dropped");

   a_stable: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_sample_count) && $stable(rsp_fault))
      else $error("waiting result changed");

   a_fault_max: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_fault) |-> (rsp_sample_count == COUNT_MAX))
      else $error("fault without saturated count");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_sample_count != 24'd0))
      else $error("zero sample count");
endmodule

bind scan_segment_sample_count_core sscnt_checker u_sscnt_checker (
   .clock(clock), .reset(reset), .empty(empty), .pop(pop),
   .rsp_sample_count(rsp_sample_count), .rsp_fault(rsp_fault)
);
`default_nettype wire

[verif/scan_segment_sample_count_core_tb.sv]
// Testbench for the scan segment sample count block: table-driven and random requests.
`timescale 1ns / 1ps
`default_nettype none
module scan_segment_sample_count_core_tb;
   import sscnt_pkg::*;

   // One request and the result it should give.
   // has_exp marks rows whose result is typed in the table.
   typedef struct {
      logic signed [31:0] sx, sy, ex, ey;
      bit                 has_exp;
      logic [23:0]        count;
      logic               fault;
   } scan_row_t;

   typedef struct {
      logic [23:0] count;
      logic        fault;
   } seg_result_t;

   localparam int CYCLE_LIMIT  = 6000000;
   localparam int RANDOM_ITEMS = 800;
   localparam int PHASES       = 6;

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   logic signed [31:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic               empty;
   logic               pop;
   logic [23:0]        rsp_sample_count;
   logic               rsp_fault;
   logic               csr_wr_en;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   // Local copy of the configuration registers
   logic [20:0] cfg_period;
   logic [31:0] cfg_acc_x, cfg_acc_y, cfg_vel_x, cfg_vel_y;

   seg_result_t pending_counts[$];
   int          error_count;
   int          cycle_count;
   int          stall_mode;   // receiver pattern: 0 never, 1 light, 2 heavy, 3 periodic

   scan_segment_sample_count_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .empty           (empty),
      .pop             (pop),
      .rsp_sample_count(rsp_sample_count),
      .rsp_fault       (rsp_fault),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // floor(sqrt(n)), bit by bit
   function automatic logic [63:0] int_sqrt(input logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         sq = {64'd0, c} * {64'd0, c};
         if (sq <= n) r = c;
      end
      return r;
   endfunction

   // Clamp a quotient into the count range; closing adds the final sample
   function automatic logic [23:0] clamp_count(input logic [127:0] q, input bit closing);
      if (q[127:24] != '0) return COUNT_MAX;
      if (closing) return (q[23:0] == COUNT_MAX) ? COUNT_MAX : q[23:0] + 24'd1;
      return (q[23:0] == 24'd0) ? 24'd1 : q[23:0];
   endfunction

   function automatic seg_result_t predict_count(input logic signed [31:0] sx, sy, ex, ey);
      seg_result_t  res;
      longint       dxs, dys;
      logic [127:0] leg_x, leg_y, path, acc, vel, prod_da, vel_sq, num, den, tmp_a, tmp_v;
      logic [127:0] per;
      dxs     = longint'(ex) - longint'(sx);
      dys     = longint'(ey) - longint'(sy);
      leg_x   = (dxs < 0) ? 128'(-dxs) : 128'(dxs);
      leg_y   = (dys < 0) ? 128'(-dys) : 128'(dys);
      path    = 128'(int_sqrt(leg_x * leg_x + leg_y * leg_y));
      per     = 128'(cfg_period);
      res.count = COUNT_MAX;
      res.fault = 1'b0;
      // Axis selection: within 0.001 rad of an axis uses that axis alone
      if ((leg_x == 0 && leg_y == 0) || ((leg_y << 32) < 128'(AXIS_TAN) * leg_x)) begin
         acc = 128'(cfg_acc_x);
         vel = 128'(cfg_vel_x);
      end else if ((leg_x << 32) < 128'(AXIS_TAN) * leg_y) begin
         acc = 128'(cfg_acc_y);
         vel = 128'(cfg_vel_y);
      end else begin
         acc   = (128'(cfg_acc_x) * path) / leg_x;
         tmp_a = (128'(cfg_acc_y) * path) / leg_y;
         if (tmp_a < acc) acc = tmp_a;
         vel   = (128'(cfg_vel_x) * path) / leg_x;
         tmp_v = (128'(cfg_vel_y) * path) / leg_y;
         if (tmp_v < vel) vel = tmp_v;
      end
      if (acc == 0) begin
         // constant speed move
         if (vel == 0) res.fault = 1'b1;
         else if (per != 0) res.count = clamp_count((path << 20) / (vel * per), 1'b0);
      end else begin
         prod_da = path * acc;
         vel_sq  = vel * vel;
         if (vel_sq < prod_da) begin
            // trapezoid: coasts at the speed limit
            if (vel == 0) res.fault = 1'b1;
            else if (per != 0) begin
               num = (vel_sq + prod_da) << 20;
               den = acc * vel * per;
               res.count = clamp_count(num / den, 1'b1);
            end
         end else if (per != 0) begin
            // triangle: never reaches the limit
            tmp_a = 128'(int_sqrt((path << 42) / acc));
            res.count = clamp_count(tmp_a / per, 1'b1);
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Register writes (only while the block is idle)
   // ---------------------------------------------------------------

   // leaves the write enable high; set_config drops it after the last write
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         CSR_SAMPLE_TIME: cfg_period = val[20:0];
         CSR_ACCEL_X:     cfg_acc_x  = val;
         CSR_ACCEL_Y:     cfg_acc_y  = val;
         CSR_VMAX_X:      cfg_vel_x  = val;
         CSR_VMAX_Y:      cfg_vel_y  = val;
         default: ;
      endcase
   endtask

   // pick an extreme or a value of random magnitude
   function automatic logic [31:0] pick_limit();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 32'd0;
      if (sel == 1) return 32'hFFFF_FFFF;
      return $urandom >> $urandom_range(0, 28);
   endfunction

   task automatic set_config(input int phase);
      case (phase)
         0: begin   // extremes high
            write_reg(CSR_SAMPLE_TIME, 32'd1);
            write_reg(CSR_ACCEL_X, 32'hFFFF_FFFF);
            write_reg(CSR_ACCEL_Y, 32'hFFFF_FFFF);
            write_reg(CSR_VMAX_X,  32'hFFFF_FFFF);
            write_reg(CSR_VMAX_Y,  32'hFFFF_FFFF);
         end
         1: begin   // longest period, constant speed moves
            write_reg(CSR_SAMPLE_TIME, 32'd1048576);
            write_reg(CSR_ACCEL_X, 32'd0);
            write_reg(CSR_ACCEL_Y, 32'd0);
            write_reg(CSR_VMAX_X,  32'd1);
            write_reg(CSR_VMAX_Y,  32'h0010_0000);
         end
         2: begin   // zero speed with acceleration: trapezoid moves fault on zero speed
            write_reg(CSR_SAMPLE_TIME, 32'd5243);
            write_reg(CSR_ACCEL_X, 32'h0100_0000);
            write_reg(CSR_ACCEL_Y, 32'd1);
            write_reg(CSR_VMAX_X,  32'd0);
            write_reg(CSR_VMAX_Y,  32'd0);
         end
         3: begin   // typical telescope limits
            write_reg(CSR_SAMPLE_TIME, 32'd5243);
            write_reg(CSR_ACCEL_X, 32'd1843200);
            write_reg(CSR_ACCEL_Y, 32'd1024000);
            write_reg(CSR_VMAX_X,  32'd614400);
            write_reg(CSR_VMAX_Y,  32'd409600);
         end
         default: begin
            write_reg(CSR_SAMPLE_TIME, 32'($urandom_range(1, 1048576)) >>
                                       $urandom_range(0, 16));
            write_reg(CSR_ACCEL_X, pick_limit());
            write_reg(CSR_ACCEL_Y, pick_limit());
            write_reg(CSR_VMAX_X,  pick_limit());
            write_reg(CSR_VMAX_Y,  pick_limit());
            if (cfg_period == 0) write_reg(CSR_SAMPLE_TIME, 32'd1);
         end
      endcase
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Request driver: bursts with random gaps
   // ---------------------------------------------------------------

   int burst_left;

   task automatic send_request(input logic signed [31:0] sx, sy, ex, ey,
                               input bit has_exp, input seg_result_t typed);
      seg_result_t want;
      int          gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      push        <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      do @(posedge clock); while (full);
      want = has_exp ? typed : predict_count(sx, sy, ex, ey);
      pending_counts.push_back(want);
      burst_left--;
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      burst_left = 0;
      while (pending_counts.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Random segment, mostly physical moves, some full-range noise
   task automatic random_request();
      logic signed [31:0] sx, sy, ex, ey;
      int                 kind;
      int                 span;
      seg_result_t        none;
      none = '{default: 0};
      kind = $urandom_range(0, 9);
      sx = $urandom;
      sy = $urandom;
      span = $urandom_range(4, 24);
      ex = sx + ($signed($urandom) >>> (32 - span));
      ey = sy + ($signed($urandom) >>> (32 - span));
      case (kind)
         0, 1: begin ex = $urandom; ey = $urandom; end
         2: ey = sy + $signed(32'($urandom_range(0, 3))) - 2;                 // on axis x
         3: ex = sx + $signed(32'($urandom_range(0, 3))) - 2;                 // on axis y
         4: ey = sy + ((ex - sx) >>> 10) + $signed(32'($urandom_range(0, 8))) - 4; // near 0.001
         5: ex = sx + ((ey - sy) >>> 10) + $signed(32'($urandom_range(0, 8))) - 4;
         6: begin ex = sx; ey = sy; end                                        // no move
         default: ;
      endcase
      send_request(sx, sy, ex, ey, 1'b0, none);
   endtask

   // Directed table. Rows with has_exp set hold results under reset defaults,
   // where both speeds are zero and every move faults.
   scan_row_t scan_table[] = '{
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1, 24'hFFFFFF, 1'b1},
      '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 24'hFFFFFF, 1'b1},
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1, 24'hFFFFFF, 1'b1},
      '{32'sh8000_0000, 32'sd0, 32'sh7FFF_FFFF, 32'sd0, 1, 24'hFFFFFF, 1'b1},
      '{32'sd0, 32'sh7FFF_FFFF, 32'sd0, 32'sh8000_0000, 1, 24'hFFFFFF, 1'b1},
      '{32'sd0, 32'sd0, 32'sd1, 32'sd0, 0, 24'd0, 1'b0},
      '{32'sd0, 32'sd0, 32'sd0, -32'sd1, 0, 24'd0, 1'b0},
      '{32'sd0, 32'sd0, 32'sd1, 32'sd1, 0, 24'd0, 1'b0},
      '{32'sd0, 32'sd0, 32'sd1000000, 32'sd1000, 0, 24'd0, 1'b0},
      '{32'sd0, 32'sd0, 32'sd1000000, 32'sd1001, 0, 24'd0, 1'b0},
      '{32'sd0, 32'sd0, 32'sd1000, 32'sd1000000, 0, 24'd0, 1'b0},
      '{32'sd0, 32'sd0, 32'sd1001, -32'sd1000000, 0, 24'd0, 1'b0},
      '{-32'sd5000, 32'sd7, 32'sd360000, -32'sd250000, 0, 24'd0, 1'b0},
      '{32'sd100, -32'sd100, 32'sd100, -32'sd100, 0, 24'd0, 1'b0},
      '{32'sh7FFF_FFFF, 32'sd0, 32'sh7FFF_FFFE, 32'sd0, 0, 24'd0, 1'b0},
      '{32'sd0, 32'sh8000_0000, 32'sd0, 32'sh8000_0001, 0, 24'd0, 1'b0}
   };

   // ---------------------------------------------------------------
   // Result checker and receiver stall pattern
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_counts.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               if (rsp_sample_count !== pending_counts[0].count)
                  report_mismatch($sformatf("sample_count %0d, expected %0d",
                                            rsp_sample_count, pending_counts[0].count));
               if (rsp_fault !== pending_counts[0].fault)
                  report_mismatch($sformatf("fault %0b, expected %0b",
                                            rsp_fault, pending_counts[0].fault));
               void'(pending_counts.pop_front());
            end
         end
         case (stall_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 7) != 0);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (cycle_count % 7) < 3;
         endcase
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------

   initial begin
      seg_result_t typed;
      error_count = 0;
      cycle_count = 0;
      stall_mode  = 0;
      burst_left  = 0;
      reset       = 1'b1;
      push        = 1'b0;
      pop         = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x   = '0;
      req_end_y   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      cfg_period  = SAMPLE_TIME_INIT;
      cfg_acc_x   = '0;
      cfg_acc_y   = '0;
      cfg_vel_x   = '0;
      cfg_vel_y   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under reset defaults: typed results where given
      foreach (scan_table[i]) begin
         typed.count = scan_table[i].count;
         typed.fault = scan_table[i].fault;
         send_request(scan_table[i].sx, scan_table[i].sy, scan_table[i].ex, scan_table[i].ey,
                      scan_table[i].has_exp, typed);
      end
      wait_drained();

      // Same rows against the predictor under typical limits
      set_config(3);
      stall_mode = 1;
      foreach (scan_table[i])
         send_request(scan_table[i].sx, scan_table[i].sy, scan_table[i].ex, scan_table[i].ey,
                      1'b0, typed);
      wait_drained();

      // Random requests over several register settings
      for (int ph = 0; ph < PHASES; ph++) begin
         set_config(ph);
         stall_mode = ph % 4;
         repeat (RANDOM_ITEMS / PHASES) random_request();
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
hdl/sscnt_pkg.sv
hdl/sscnt_fifo.sv
hdl/sscnt_front.sv
hdl/sscnt_alu.sv
hdl/sscnt_back.sv
hdl/scan_segment_sample_count_core.sv
hdl/sscnt_checker.sv
verif/scan_segment_sample_count_core_tb.sv
